@@ rtl/core/assert_macros.svh @@
// assertion macros, included by the conversion engine rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

@@ rtl/core/b2a_pkg.sv @@
// shared types, constants and helpers of the binary to ascii digit unit
package b2a_pkg;

   localparam int VALUE_BITS = 32;
   localparam int TDATA_W    = ((VALUE_BITS + 7) / 8) * 8;
   localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int DIG_BITS   = DEC_DIGITS * 4;
   localparam int REM_W      = $clog2(DEC_DIGITS + 1);
   localparam int CNT_W      = $clog2(VALUE_BITS);
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

   localparam logic KIND_DEC = 1'b0;
   localparam logic KIND_HEX = 1'b1;

   localparam logic [7:0] ASCII_ZERO   = 8'h30;
   localparam logic [7:0] ASCII_LETTER = 8'h37;

   typedef struct packed {
      logic                  hex;
      logic [VALUE_BITS-1:0] value;
   } item_type;

   // nibble to ascii, digits above nine become upper-case letters
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] res;
      if (nib <= 4'd9) begin
         res = ASCII_ZERO + {4'd0, nib};
      end else begin
         res = ASCII_LETTER + {4'd0, nib};
      end
      return res;
   endfunction

   // one double-dabble step: correct each bcd digit, then shift in one bit
   function automatic logic [DIG_BITS-1:0] dabble(input logic [DIG_BITS-1:0] dig,
                                                  input logic               bit_in);
      logic [DIG_BITS-1:0] adj;
      adj = dig;
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (adj[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = adj[i*4 +: 4] + 4'd3;
         end
      end
      return {adj[DIG_BITS-2:0], bit_in};
   endfunction

endpackage

@@ rtl/core/binary_to_ascii_digits_unit.sv @@
// top level of the binary to ascii digit unit
//
// usage:
//   request channel: req_tdata carries the value, req_tuser the kind
//   (0 decimal, 1 hexadecimal); a transfer hands over one number
//   response channel: one transfer per ascii character, most significant
//   digit first, leading zeros dropped, rsp_tlast on the final character;
//   a zero value gives the single character '0'
//   work starts once a number has passed the input stage, the queue and the
//   engine; decimal first runs a bit-serial bcd conversion (one step per
//   value bit), then drops leading zeros and emits the characters, while hex
//   goes straight to dropping leading zeros and emitting; the single shared
//   conversion engine takes a new number only once its previous run is done
//   a two-entry queue lets the input side take further numbers while the
//   engine works or the receiver stalls; when rsp_tready stays low the
//   engine holds its character in the output register and pauses
//   reset (synchronous, active high) empties the queue and the output
//   register and returns the engine to idle
module binary_to_ascii_digits_unit
   import b2a_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,  // [31:0] value
   input  logic               req_tuser,  // [0] kind
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,  // [7:0] char_out
   output logic               rsp_tlast
);

   // front to queue
   logic     push;
   logic     push_ready;
   item_type push_item;

   // queue to engine
   logic     pop;
   logic     pop_valid;
   item_type pop_item;

   b2a_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   b2a_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   // engine owns the output register that feeds the response channel
   b2a_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/core/b2a_front.sv @@
// input stage: takes items from the request channel and classifies them
module b2a_front
   import b2a_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,
   input  logic               req_tuser,
   output logic               push,
   output item_type           push_item,
   input  logic               push_ready
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_tready = !valid_ff || push_ready;
   assign take       = req_tvalid && req_tready;
   assign push       = valid_ff && push_ready;
   assign push_item  = item_ff;

   always_comb begin
      valid_in = take || (valid_ff && !push_ready);
      item_in  = item_ff;
      if (take) begin
         item_in.hex   = (req_tuser == KIND_HEX);
         item_in.value = req_tdata[VALUE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

@@ rtl/core/b2a_queue.sv @@
// short fifo between the input stage and the conversion engine
module b2a_queue
   import b2a_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     push_ready,
   input  logic     pop,
   output logic     pop_valid,
   output item_type pop_item
);

   item_type             mem [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;

   assign push_ready = (cnt_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/b2a_back.sv @@
// conversion engine: bit-serial bcd conversion and digit emission
module b2a_back
   import b2a_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  item_type           pop_item,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast
);

`include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [DIG_BITS-1:0]   dig_ff, dig_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic                  started_ff, started_in;
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_free;
   logic                  emit;
   logic [3:0]            top_nib;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign top_nib    = dig_ff[DIG_BITS-1 -: 4];
   assign pop        = (state_ff == ST_IDLE) && pop_valid;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      dig_in       = dig_ff;
      val_in       = val_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      started_in   = started_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      emit         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               rem_in     = REM_W'(DEC_DIGITS);
               started_in = 1'b0;
               cnt_in     = CNT_W'(VALUE_BITS - 1);
               val_in     = pop_item.value;
               if (pop_item.hex) begin
                  // hex digits are the value's nibbles as they stand
                  dig_in   = {{(DIG_BITS - VALUE_BITS){1'b0}}, pop_item.value};
                  state_in = ST_EMIT;
               end else begin
                  dig_in   = '0;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            dig_in = dabble(dig_ff, val_ff[VALUE_BITS-1]);
            val_in = {val_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!started_ff && top_nib == 4'd0 && rem_ff != REM_W'(1)) begin
               // leading zero, dropped without an output slot
               dig_in = {dig_ff[DIG_BITS-5:0], 4'd0};
               rem_in = rem_ff - 1'b1;
            end else if (out_free) begin
               emit         = 1'b1;
               out_valid_in = 1'b1;
               out_char_in  = hex_char(top_nib);
               out_last_in  = (rem_ff == REM_W'(1));
               started_in   = 1'b1;
               dig_in       = {dig_ff[DIG_BITS-5:0], 4'd0};
               rem_in       = rem_ff - 1'b1;
               if (rem_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff      <= dig_in;
      val_ff      <= val_in;
      cnt_ff      <= cnt_in;
      rem_ff      <= rem_in;
      started_ff  <= started_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   `ASSERT_CLK(a_emit_rem_nonzero, clock, reset, (state_ff == ST_EMIT) |-> (rem_ff != '0), "digit count ran out while emitting")
   `ASSERT_CLK(a_last_ends_run, clock, reset, (emit && out_last_in) |=> (state_ff == ST_IDLE), "engine did not return to idle after last character")
   `ASSERT_NEVER(a_pop_while_busy, clock, reset, emit && pop, "new item taken while a run is emitted")
   `ASSERT_CLK(a_conv_no_output, clock, reset, (state_ff == ST_CONV) |=> !(out_valid_ff && !$past(out_valid_ff)), "character produced during conversion")

endmodule

@@ tb/tb_top.sv @@
// self-checking testbench of the binary to ascii digit unit: directed table, then random numbers
`timescale 1ns / 100ps

module tb_top
   import b2a_pkg::*;
();

   localparam byte unsigned CHAR_ZERO    = "0";
   localparam byte unsigned CHAR_UPPER_A = "A";
   localparam int           RANDOM_ITEMS = 500;
   localparam int           LONG_HOLD    = 400;

   // one expected character of a run
   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } glyph_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata = '0;   // [31:0] value
   logic               req_tuser = 1'b0; // [0] kind
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;        // [7:0] char_out
   logic               rsp_tlast;

   glyph_type pending_glyphs [$];
   int        error_count = 0;
   bit        calm = 1'b0;      // no random idling on either side while set
   bit        hold_req = 1'b0;  // asks the receiver for one long stall

   // directed table: kind, value and, where obvious, the text to expect
   logic               row_kind [$];
   logic [31:0]        row_value [$];
   string              row_text [$];

   binary_to_ascii_digits_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // digits of one number, least significant first, then queued in print order
   function automatic void predict_digits(input logic kind, input logic [VALUE_BITS-1:0] value);
      logic [7:0]  rev [$];
      logic [63:0] rest;
      logic [3:0]  nib;
      rest = 64'(value);
      do begin
         if (kind == KIND_HEX) begin
            nib = rest[3:0];
            rev.push_back(nib <= 4'd9 ? CHAR_ZERO + nib : CHAR_UPPER_A + (nib - 4'd10));
            rest = rest >> 4;
         end else begin
            rev.push_back(CHAR_ZERO + 8'(rest % 64'd10));
            rest = rest / 64'd10;
         end
      end while (rest != 0);
      for (int i = rev.size() - 1; i >= 0; i--) begin
         pending_glyphs.push_back(glyph_type'{rev[i], i == 0});
      end
   endfunction

   task automatic add_row(input logic kind, input logic [31:0] value, input string text);
      row_kind.push_back(kind);
      row_value.push_back(value);
      row_text.push_back(text);
   endtask

   // offer one number after a random gap; returns at the edge of its transfer
   task automatic send_number(input logic kind, input logic [31:0] value, input string text);
      int gap;
      gap = calm ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= TDATA_W'($urandom);
         req_tuser  <= 1'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'(value);
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (text.len() > 0) begin
         for (int i = 0; i < text.len(); i++) begin
            pending_glyphs.push_back(glyph_type'{text[i], i == text.len() - 1});
         end
      end else begin
         predict_digits(kind, VALUE_BITS'(value));
      end
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_glyphs.size() != 0) @(posedge clock);
   endtask

   task automatic send_random();
      logic        kind;
      logic [31:0] value;
      logic [63:0] decade;
      int          pick;
      kind = 1'($urandom);
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         // around powers of ten, where the digit count changes
         decade = 64'd1;
         repeat ($urandom_range(0, 9)) decade = decade * 64'd10;
         value = 32'(decade - 64'($urandom_range(0, 1)));
      end else if (pick < 4) begin
         value = $urandom;
      end else begin
         // short values so every run length shows up
         value = $urandom >> $urandom_range(0, 31);
      end
      send_number(kind, value, "");
   endtask

   // receiver: random stalls, plus one long hold-off counted here
   initial begin : rsp_side
      int idle_left;
      idle_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            idle_left = LONG_HOLD;
         end
         if (idle_left > 0) begin
            rsp_tready <= 1'b0;
            idle_left--;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            idle_left = pick_gap();
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // every character transfer is compared with the oldest expectation
   always @(posedge clock) begin
      glyph_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_glyphs.size() == 0) begin
            $display("%0t: unexpected character %h last %b", $time, rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = pending_glyphs.pop_front();
            if (rsp_tdata !== want.code || rsp_tlast !== want.last) begin
               $display("%0t: char expected %h got %h, last expected %b got %b",
                        $time, want.code, rsp_tdata, want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(KIND_DEC, 32'd0,          "0");
      add_row(KIND_HEX, 32'd0,          "0");
      add_row(KIND_DEC, 32'd1,          "1");
      add_row(KIND_HEX, 32'd1,          "1");
      add_row(KIND_DEC, 32'd9,          "9");
      add_row(KIND_DEC, 32'd10,         "10");
      add_row(KIND_HEX, 32'h0000000A,   "A");
      add_row(KIND_HEX, 32'h0000000F,   "F");
      add_row(KIND_HEX, 32'h00000010,   "10");
      add_row(KIND_DEC, 32'd99,         "99");
      add_row(KIND_DEC, 32'd100,        "100");
      add_row(KIND_DEC, 32'd999999999,  "999999999");
      add_row(KIND_DEC, 32'd1000000000, "1000000000");
      add_row(KIND_DEC, 32'hFFFFFFFF,   "4294967295");
      add_row(KIND_HEX, 32'hFFFFFFFF,   "FFFFFFFF");
      add_row(KIND_DEC, 32'h80000000,   "2147483648");
      add_row(KIND_HEX, 32'h80000000,   "80000000");
      add_row(KIND_HEX, 32'hABCDEF01,   "ABCDEF01");
      add_row(KIND_DEC, 32'hAAAAAAAA,   "");
      add_row(KIND_HEX, 32'h55555555,   "");
      add_row(KIND_DEC, 32'h7FFFFFFF,   "");
      add_row(KIND_HEX, 32'h0123BEEF,   "");

      for (int i = 0; i < row_kind.size(); i++) begin
         send_number(row_kind[i], row_value[i], row_text[i]);
      end

      // back to back at full rate
      calm = 1'b1;
      for (int i = 0; i < 60; i++) send_random();

      // receiver holds off while numbers keep coming, so the input side backs up
      hold_req = 1'b1;
      for (int i = 0; i < 12; i++) send_random();
      calm = 1'b0;

      // sender waits for every character before going on
      drop_valid();
      drain();

      for (int i = 0; i < RANDOM_ITEMS - 72; i++) begin
         send_random();
         if ($urandom_range(0, 99) == 0) begin
            drop_valid();
            drain();
         end
      end
      drop_valid();

      drain();
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
